// ===== rtl/pidaw_pkg.sv =====
// Package for the PID controller with conditional integration.
// Holds the field widths, reset constants and configuration register indexes.
// Used by the channel interfaces and by the top level.
package pidaw_pkg;

	// Field widths fixed by the data format.
	localparam int DATA_W  = 32;
	localparam int GAIN_W  = 24;
	localparam int HIST_W  = 48;
	localparam int LIMIT_W = 31;

	// Default number of fraction bits and the default integral limit in whole units.
	localparam int FRAC_BITS_DEF  = 16;
	localparam int INTEGRAL_UNITS = 400;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_UPPER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOWER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;

endpackage

// ===== rtl/pidaw_sample_if.sv =====
// Input channel of the PID controller: one error sample and a clear flag per word.
// Depends on pidaw_pkg for the field widths.
interface pidaw_sample_if
	import pidaw_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] error_in;
	logic                     clear;

	modport source (output valid, output error_in, output clear, input ready);
	modport sink (input valid, input error_in, input clear, output ready);
endinterface

// ===== rtl/pidaw_result_if.sv =====
// Output channel of the PID controller: the clamped drive and the saturation flag.
// Depends on pidaw_pkg for the field widths.
interface pidaw_result_if
	import pidaw_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic                     saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink (input valid, input drive, input saturated, output ready);
endinterface

// ===== rtl/pid_controller_anti_windup.sv =====
// Positional PID controller with conditional integration, signed fixed point.
// Each accepted sample word passes through the input register, then one compute pass
// into the result register. The integral and history feed back in one pass.
// Throughput: one word per cycle while the result channel is not stalled.
// Reset (arst_n low, asynchronous): gains 0, output limits +/-1.0, integral limit 400.0
// (saturated to the 31-bit range), integral, previous error and history cleared.
module pid_controller_anti_windup
	import pidaw_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [DATA_W-1:0]    cfg_wdata,
	pidaw_sample_if.sink         sample,
	pidaw_result_if.source       result
);

	// Derived widths and reset values.
	localparam int PROD_W = GAIN_W + DATA_W;
	localparam int DIFF_W = DATA_W + 1;
	localparam int ACC_W  = GAIN_W + DATA_W + 3;
	localparam int SUM_W  = DATA_W + 1;
	localparam logic [63:0] LimWide = 64'(INTEGRAL_UNITS) << FRAC_BITS;
	localparam logic [LIMIT_W-1:0] LimReset =
		(LimWide > 64'h7FFF_FFFF) ? {LIMIT_W{1'b1}} : LimWide[LIMIT_W-1:0];
	localparam logic signed [DATA_W-1:0] UpperReset = DATA_W'(64'd1 << FRAC_BITS);
	localparam logic signed [DATA_W-1:0] LowerReset = -UpperReset;
	localparam logic signed [HIST_W-1:0] HistMax = {1'b0, {(HIST_W-1){1'b1}}};
	localparam logic signed [HIST_W-1:0] HistMin = {1'b1, {(HIST_W-1){1'b0}}};

	// Configuration registers.
	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic signed [DATA_W-1:0]  upper_q, lower_q;
	logic        [LIMIT_W-1:0] limit_q;

	// Input stage and state.
	logic                     valid_s1;
	logic signed [DATA_W-1:0] error_s1;
	logic                     clear_s1;
	logic signed [DATA_W-1:0] integral_q;
	logic signed [DATA_W-1:0] prev_error_q;
	logic signed [HIST_W-1:0] hist_q;

	// Result register.
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     sat_q;

	// Compute pass.
	logic                     advance;
	logic signed [HIST_W-1:0] upper_ext, lower_ext;
	logic                     hist_out, integrate;
	logic signed [SUM_W-1:0]  sum_raw, limit_pos, limit_neg;
	logic signed [DATA_W-1:0] integral_new;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod_p, prod_i;
	logic signed [PROD_W:0]   prod_d;
	logic signed [ACC_W-1:0]  acc, shifted;
	logic signed [HIST_W-1:0] hist_new;
	logic signed [DATA_W-1:0] drive_new;
	logic                     sat_new;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			upper_q  <= UpperReset;
			lower_q  <= LowerReset;
			limit_q  <= LimReset;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_GAIN_P:         gain_p_q <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_I:         gain_i_q <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_D:         gain_d_q <= cfg_wdata[GAIN_W-1:0];
				REG_OUTPUT_UPPER:   upper_q  <= cfg_wdata;
				REG_OUTPUT_LOWER:   lower_q  <= cfg_wdata;
				REG_INTEGRAL_LIMIT: limit_q  <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register is free or drained.
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			error_s1 <= sample.error_in;
			clear_s1 <= sample.clear;
		end
	end

	// Conditional integration: with the history outside the limits, integrate only
	// when the error sign is strictly opposite to the history sign.
	always_comb begin
		upper_ext = HIST_W'(upper_q);
		lower_ext = HIST_W'(lower_q);
		hist_out  = (hist_q > upper_ext) || (hist_q < lower_ext);
		integrate = !hist_out ||
			(hist_q > 0 && error_s1 < 0) || (hist_q < 0 && error_s1 > 0);
		sum_raw   = SUM_W'(integral_q) + (integrate ? SUM_W'(error_s1) : '0);
		limit_pos = SUM_W'({1'b0, limit_q});
		limit_neg = -limit_pos;
		if (sum_raw > limit_pos) begin
			integral_new = DATA_W'(limit_pos);
		end else if (sum_raw < limit_neg) begin
			integral_new = DATA_W'(limit_neg);
		end else begin
			integral_new = sum_raw[DATA_W-1:0];
		end
	end

	// Three products summed at full precision, floor shift, saturation to the history range.
	always_comb begin
		diff    = DIFF_W'(error_s1) - DIFF_W'(prev_error_q);
		prod_p  = gain_p_q * error_s1;
		prod_i  = gain_i_q * integral_new;
		prod_d  = gain_d_q * diff;
		acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
		shifted = acc >>> FRAC_BITS;
		if (shifted[ACC_W-1:HIST_W-1] == '0 || shifted[ACC_W-1:HIST_W-1] == '1) begin
			hist_new = shifted[HIST_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			hist_new = HistMin;
		end else begin
			hist_new = HistMax;
		end
	end

	// Output clamp: upper limit first, then lower, so inverted limits end at the lower one.
	always_comb begin
		drive_new = hist_new[DATA_W-1:0];
		sat_new   = 1'b0;
		if (hist_new > upper_ext) begin
			drive_new = upper_q;
			sat_new   = 1'b1;
		end
		if ((sat_new ? HIST_W'(upper_q) : hist_new) < lower_ext) begin
			drive_new = lower_q;
			sat_new   = 1'b1;
		end
	end

	// Controller state, updated as each word passes into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			prev_error_q <= '0;
			hist_q       <= '0;
		end else if (advance) begin
			if (clear_s1) begin
				integral_q   <= '0;
				prev_error_q <= '0;
				hist_q       <= '0;
			end else begin
				integral_q   <= integral_new;
				prev_error_q <= error_s1;
				hist_q       <= hist_new;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= clear_s1 ? '0 : drive_new;
			sat_q   <= clear_s1 ? 1'b0 : sat_new;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.drive     = drive_q;
	assign result.saturated = sat_q;

endmodule

// ===== test/tb.sv =====
// Testbench for the PID controller with conditional integration.
// Drives sample words, predicts each result word in fixed point and checks it field by field.
// Depends on pidaw_pkg, pidaw_sample_if, pidaw_result_if and pid_controller_anti_windup.
module tb;
	import pidaw_pkg::*;

	// Indexes that map to no register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam int     FRAC     = FRAC_BITS_DEF;
	localparam longint ONE      = longint'(1) << FRAC;
	localparam longint HIST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint HIST_MIN = -HIST_MAX - 1;

	typedef struct {
		logic signed [DATA_W-1:0] err;
		logic                     clr;
	} sample_word_t;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		logic                     saturated;
	} result_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [DATA_W-1:0] cfg_wdata;

	pidaw_sample_if sample_ch ();
	pidaw_result_if result_ch ();

	pid_controller_anti_windup i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	// Register copies as seen by the controller.
	longint kp, ki, kd, out_hi, out_lo, integ_lim;
	// Controller state copies.
	longint integ, prev_err, hist;

	sample_word_t pending_samples[$];
	result_word_t expected_results[$];

	int  words_queued;
	int  words_in;
	int  words_out;
	int  mismatches;
	bit  sample_taken;
	bit  result_taken;
	bit  offering;
	bit  send_calm;
	bit  recv_calm;
	bit  long_stall;
	int  send_gap;
	int  recv_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog for a hung run.
	initial begin
		#4000000;
		$display("tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("tb: mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 15));
	endfunction

	// One controller step in 64-bit arithmetic: conditional integration, clamped
	// integral, three products, floor shift, 48-bit history saturation, output clamp.
	function automatic result_word_t step_controller(input sample_word_t w);
		result_word_t r;
		longint e, acc, u, y;
		r.saturated = 1'b0;
		if (w.clr) begin
			integ    = 0;
			prev_err = 0;
			hist     = 0;
			r.drive  = '0;
			return r;
		end
		e = w.err;
		if (hist > out_hi || hist < out_lo) begin
			if ((hist > 0 && e < 0) || (hist < 0 && e > 0))
				integ += e;
		end else begin
			integ += e;
		end
		if (integ > integ_lim)
			integ = integ_lim;
		else if (integ < -integ_lim)
			integ = -integ_lim;
		acc = kp * e + ki * integ + kd * (e - prev_err);
		u = acc >>> FRAC;
		if (u > HIST_MAX)
			u = HIST_MAX;
		if (u < HIST_MIN)
			u = HIST_MIN;
		prev_err = e;
		hist     = u;
		y = u;
		if (y > out_hi) begin
			y = out_hi;
			r.saturated = 1'b1;
		end
		if (y < out_lo) begin
			y = out_lo;
			r.saturated = 1'b1;
		end
		r.drive = y[DATA_W-1:0];
		return r;
	endfunction

	task automatic check_result();
		result_word_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result word drive=%0d",
				result_ch.drive));
			return;
		end
		want = expected_results.pop_front();
		if (result_ch.drive !== want.drive)
			report_mismatch($sformatf("drive %0d, expected %0d",
				result_ch.drive, want.drive));
		if (result_ch.saturated !== want.saturated)
			report_mismatch($sformatf("saturated %0b, expected %0b",
				result_ch.saturated, want.saturated));
	endtask

	// Monitor: mirrors register writes, predicts accepted words, checks results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen) begin
				case (cfg_addr)
					REG_GAIN_P:         kp = $signed(cfg_wdata[GAIN_W-1:0]);
					REG_GAIN_I:         ki = $signed(cfg_wdata[GAIN_W-1:0]);
					REG_GAIN_D:         kd = $signed(cfg_wdata[GAIN_W-1:0]);
					REG_OUTPUT_UPPER:   out_hi = $signed(cfg_wdata);
					REG_OUTPUT_LOWER:   out_lo = $signed(cfg_wdata);
					REG_INTEGRAL_LIMIT: integ_lim = cfg_wdata[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (sample_ch.valid && sample_ch.ready) begin
				sample_word_t w;
				w.err = sample_ch.error_in;
				w.clr = sample_ch.clear;
				expected_results.push_back(step_controller(w));
				words_in++;
				sample_taken = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				check_result();
				words_out++;
				result_taken = 1'b1;
			end
		end
	end

	// Sample driver: one word at a time from the pending queue, random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (sample_taken) begin
				sample_taken = 1'b0;
				offering     = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_samples.size() > 0) begin
					sample_word_t w;
					w = pending_samples.pop_front();
					offering = 1'b1;
					if ($urandom_range(0, 63) == 0)
						send_calm = !send_calm;
					send_gap = draw_gap(send_calm);
					sample_ch.error_in <= w.err;
					sample_ch.clear    <= w.clr;
				end
			end
			sample_ch.valid <= offering;
		end
	end

	// Result receiver: random hold after each word, plus the long stall.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken) begin
				result_taken = 1'b0;
				if ($urandom_range(0, 63) == 0)
					recv_calm = !recv_calm;
				recv_hold = draw_gap(recv_calm);
			end
			if (recv_hold > 0) begin
				recv_hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !long_stall;
			end
		end
	end

	// Long receiver stall in the middle of the random part so the block backs up.
	initial begin
		long_stall = 1'b0;
		while (words_in < 400)
			@(posedge clk);
		long_stall = 1'b1;
		repeat (300) @(posedge clk);
		long_stall = 1'b0;
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic queue_word(input logic signed [DATA_W-1:0] err, input logic clr);
		sample_word_t w;
		w.err = err;
		w.clr = clr;
		pending_samples.push_back(w);
		words_queued++;
	endtask

	task automatic wait_idle();
		while (words_out != words_queued)
			@(posedge clk);
	endtask

	// Gains: extremes, zero, full random or within +/-2.0; upper byte is don't-care.
	function automatic logic [DATA_W-1:0] pick_gain();
		logic [DATA_W-1:0] w;
		w = $urandom();
		case ($urandom_range(0, 5))
			0: w[GAIN_W-1:0] = 24'h7FFFFF;
			1: w[GAIN_W-1:0] = 24'h800000;
			2: w[GAIN_W-1:0] = 24'h000000;
			3: ;
			default: w[GAIN_W-1:0] = 24'($urandom_range(0, 262144)) - 24'd131072;
		endcase
		return w;
	endfunction

	function automatic logic [DATA_W-1:0] pick_bound();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom();
			default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
		endcase
	endfunction

	// Integral limit: bit 31 of the write data is random and must be dropped.
	function automatic logic [DATA_W-1:0] pick_limit();
		logic [DATA_W-1:0] w;
		w = $urandom();
		case ($urandom_range(0, 5))
			0: w[LIMIT_W-1:0] = '0;
			1: w[LIMIT_W-1:0] = '1;
			2: ;
			default: w[LIMIT_W-1:0] = 31'($urandom_range(0, 3276800));
		endcase
		return w;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_error();
		case ($urandom_range(0, 7))
			0, 1: return $urandom();
			2: return 32'h7FFFFFFF;
			3: return 32'h80000000;
			4: return '0;
			default: return 32'($urandom_range(0, 1048576)) - 32'd524288;
		endcase
	endfunction

	initial begin
		kp        = 0;
		ki        = 0;
		kd        = 0;
		out_hi    = ONE;
		out_lo    = -ONE;
		integ_lim = longint'(INTEGRAL_UNITS) << FRAC;
		integ     = 0;
		prev_err  = 0;
		hist      = 0;
		words_queued = 0;
		words_in     = 0;
		words_out    = 0;
		mismatches   = 0;
		sample_taken = 1'b0;
		result_taken = 1'b0;
		offering     = 1'b0;
		send_calm    = 1'b0;
		recv_calm    = 1'b0;
		send_gap     = 0;
		recv_hold    = 0;
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		sample_ch.valid    = 1'b0;
		sample_ch.error_in = '0;
		sample_ch.clear    = 1'b0;
		result_ch.ready    = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero gains give zero drive; clear ignores its error.
		queue_word(32'h7FFFFFFF, 1'b0);
		queue_word(32'h80000000, 1'b0);
		queue_word(ONE[31:0], 1'b1);
		wait_idle();

		// Moderate gains, +/-10.0 output range, integral limit 100.0.
		cfg_write(REG_GAIN_P, ONE[31:0]);
		cfg_write(REG_GAIN_I, 32'(ONE / 2));
		cfg_write(REG_GAIN_D, 32'(ONE / 4));
		cfg_write(REG_OUTPUT_UPPER, 32'(10 * ONE));
		cfg_write(REG_OUTPUT_LOWER, 32'(-10 * ONE));
		cfg_write(REG_INTEGRAL_LIMIT, 32'(100 * ONE));
		queue_word('0, 1'b0);
		queue_word(32'(3 * ONE), 1'b0);
		// Saturate high, then same-sign and zero error must hold the integral.
		queue_word(32'h7FFFFFFF, 1'b0);
		queue_word(ONE[31:0], 1'b0);
		queue_word('0, 1'b0);
		// Opposite sign integrates again; then saturate low and recover.
		queue_word(32'(-ONE), 1'b0);
		queue_word(32'h80000000, 1'b0);
		queue_word(32'(2 * ONE), 1'b0);
		queue_word(32'(7 * ONE), 1'b1);
		queue_word(32'(-5 * ONE), 1'b0);
		wait_idle();

		// Inverted limits: zero history lies out of range, so integration holds.
		cfg_write(REG_OUTPUT_UPPER, ONE[31:0]);
		cfg_write(REG_OUTPUT_LOWER, 32'(2 * ONE));
		queue_word('0, 1'b1);
		queue_word(32'(3 * ONE), 1'b0);
		queue_word(32'(-3 * ONE), 1'b0);
		queue_word('0, 1'b0);
		wait_idle();

		// Random part: two extreme settings, then random settings.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) begin
				cfg_write(REG_GAIN_P, 32'h007FFFFF);
				cfg_write(REG_GAIN_I, 32'h007FFFFF);
				cfg_write(REG_GAIN_D, 32'h007FFFFF);
				cfg_write(REG_OUTPUT_UPPER, 32'h7FFFFFFF);
				cfg_write(REG_OUTPUT_LOWER, 32'h80000000);
				cfg_write(REG_INTEGRAL_LIMIT, 32'hFFFFFFFF);
			end else if (ph == 1) begin
				cfg_write(REG_GAIN_P, 32'hFF800000);
				cfg_write(REG_GAIN_I, 32'h00800000);
				cfg_write(REG_GAIN_D, 32'h00800000);
				cfg_write(REG_OUTPUT_UPPER, '0);
				cfg_write(REG_OUTPUT_LOWER, '0);
				cfg_write(REG_INTEGRAL_LIMIT, 32'h80000000);
			end else begin
				cfg_write(REG_GAIN_P, pick_gain());
				cfg_write(REG_GAIN_I, pick_gain());
				cfg_write(REG_GAIN_D, pick_gain());
				cfg_write(REG_OUTPUT_UPPER, pick_bound());
				cfg_write(REG_OUTPUT_LOWER, pick_bound());
				cfg_write(REG_INTEGRAL_LIMIT, pick_limit());
			end
			cfg_write(REG_SPARE_A, $urandom());
			cfg_write(REG_SPARE_B, $urandom());
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 235; n++)
				queue_word(pick_error(), $urandom_range(0, 29) == 0);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pidaw_pkg.sv
rtl/pidaw_sample_if.sv
rtl/pidaw_result_if.sv
rtl/pid_controller_anti_windup.sv
test/tb.sv
